@@ hw/rtl/tslot_pkg.sv @@
// Shared types, constants and helpers of the timer slot table.
package tslot_pkg;

  localparam int TIMER_SLOTS = 4096;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int ID_W        = 32;
  localparam int TIME_W      = 48;
  localparam int DELAY_W     = 32;
  localparam int REGION_W    = 32;

  localparam logic [1:0] CMD_CREATE        = 2'd0;
  localparam logic [1:0] CMD_POLL          = 2'd1;
  localparam logic [1:0] CMD_CANCEL        = 2'd2;
  localparam logic [1:0] CMD_CANCEL_REGION = 2'd3;

  localparam logic [1:0] STAT_PENDING   = 2'd0;
  localparam logic [1:0] STAT_COMPLETED = 2'd1;
  localparam logic [1:0] STAT_CANCELLED = 2'd2;

  localparam logic [1:0] OUTC_NOT_DUE   = 2'd0;
  localparam logic [1:0] OUTC_COMPLETED = 2'd1;
  localparam logic [1:0] OUTC_GONE      = 2'd2;
  localparam logic [1:0] OUTC_INVALID   = 2'd3;

  localparam logic ALU_ADD_SAT = 1'b0;
  localparam logic ALU_GE      = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]     owner;
    logic [TIME_W-1:0]   fire;
    logic [REGION_W-1:0] region;
    logic [1:0]          status;
  } entry_t;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
  } mem_req_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] rem;
    rem = id % TIMER_SLOTS;
    return rem[SLOT_W-1:0];
  endfunction

endpackage

@@ hw/rtl/tslot_mem.sv @@
// Slot storage: one write port, one registered read port.
module tslot_mem (
  input  logic                clk,
  input  tslot_pkg::mem_req_t req,
  output tslot_pkg::entry_t   rdata
);

  tslot_pkg::entry_t mem [tslot_pkg::TIMER_SLOTS];
  tslot_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/tslot_alu.sv @@
// Shared time unit: saturating add or unsigned greater-or-equal compare.
module tslot_alu (
  input  logic                          op,
  input  logic [tslot_pkg::TIME_W-1:0]  a,
  input  logic [tslot_pkg::TIME_W-1:0]  b,
  output logic [tslot_pkg::TIME_W-1:0]  res
);

  logic [tslot_pkg::TIME_W:0] sum;

  assign sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    unique case (op)
      tslot_pkg::ALU_ADD_SAT: begin
        res = sum[tslot_pkg::TIME_W] ? {tslot_pkg::TIME_W{1'b1}} : sum[tslot_pkg::TIME_W-1:0];
      end
      tslot_pkg::ALU_GE: begin
        res = {{(tslot_pkg::TIME_W-1){1'b0}}, (a >= b)};
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/timer_slot_table_top.sv @@
// Timer slot table top level: command sequencer, slot memory and time unit.
// Create, poll and cancel: a slot read, then the update and the result, with in_stall high.
// Region cancel: one slot read, and written back if it hits, per cycle; region 0 skips the sweep.
// A stalled result holds the sequencer in its update step until the transfer.
// After reset the block clears every slot owner, one slot a cycle, with
// in_stall high; rst_n is synchronous.
module timer_slot_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [47:0] in_now_ms,
  input  logic [31:0] in_delay_ms,
  input  logic [31:0] in_timer_id,
  input  logic [31:0] in_region_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_new_id,
  output logic [1:0]  out_outcome,
  output logic        out_cancel_ok,
  output logic        out_fired
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  localparam logic [tslot_pkg::CNT_W-1:0] SLOTS_CNT = tslot_pkg::CNT_W'(tslot_pkg::TIMER_SLOTS);
  localparam logic [tslot_pkg::CNT_W-1:0] LAST_CNT  =
    tslot_pkg::CNT_W'(tslot_pkg::TIMER_SLOTS - 1);

  logic [1:0]                        state_r, state_nxt;
  logic [tslot_pkg::CNT_W-1:0]       idx_r, idx_nxt, idx_m1;
  logic [tslot_pkg::ID_W-1:0]        id_cnt_r, id_cnt_nxt, next_id;
  logic                              any_r, any_nxt;
  logic                              out_valid_r, out_valid_nxt;

  logic [1:0]                        cmd_r;
  logic [tslot_pkg::TIME_W-1:0]      now_r;
  logic [tslot_pkg::DELAY_W-1:0]     delay_r;
  logic [tslot_pkg::ID_W-1:0]        id_r;
  logic [tslot_pkg::REGION_W-1:0]    region_r;
  logic [tslot_pkg::SLOT_W-1:0]      slot_r;

  logic [31:0]                       new_id_r, res_new_id;
  logic [1:0]                        outcome_r, res_outcome;
  logic                              cancel_ok_r, res_cancel_ok;
  logic                              fired_r, res_fired;

  logic                              in_xfer, out_free, out_load, hit;
  logic                              exec_we;
  tslot_pkg::entry_t                 exec_wdata, rdata;
  tslot_pkg::mem_req_t               req;
  logic                              alu_op;
  logic [tslot_pkg::TIME_W-1:0]      alu_b, alu_res;
  logic [tslot_pkg::SLOT_W-1:0]      accept_slot;

  tslot_mem u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  tslot_alu u_alu (
    .op  (alu_op),
    .a   (now_r),
    .b   (alu_b),
    .res (alu_res)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_EXEC) && out_free;
  assign next_id  = (id_cnt_r == '1) ? 32'd1 : id_cnt_r + 32'd1;
  assign idx_m1   = idx_r - tslot_pkg::CNT_W'(1);

  assign hit = (rdata.owner != '0) && (rdata.region == region_r) &&
               (rdata.status == tslot_pkg::STAT_PENDING);

  always_comb begin
    priority if (in_cmd == tslot_pkg::CMD_CREATE) begin
      accept_slot = tslot_pkg::slot_of(next_id);
    end else if (in_cmd == tslot_pkg::CMD_CANCEL_REGION) begin
      accept_slot = '0;
    end else begin
      accept_slot = tslot_pkg::slot_of(in_timer_id);
    end
  end

  // update step of a single-slot command, and the result of a region cancel
  always_comb begin
    alu_op        = (cmd_r == tslot_pkg::CMD_CREATE) ? tslot_pkg::ALU_ADD_SAT : tslot_pkg::ALU_GE;
    alu_b         = (cmd_r == tslot_pkg::CMD_CREATE) ?
                    {{(tslot_pkg::TIME_W-tslot_pkg::DELAY_W){1'b0}}, delay_r} : rdata.fire;
    exec_we       = 1'b0;
    exec_wdata    = rdata;
    res_new_id    = '0;
    res_outcome   = tslot_pkg::OUTC_NOT_DUE;
    res_cancel_ok = 1'b0;
    res_fired     = 1'b0;
    unique case (cmd_r)
      tslot_pkg::CMD_CREATE: begin
        exec_we           = 1'b1;
        exec_wdata.owner  = id_r;
        exec_wdata.fire   = alu_res;
        exec_wdata.region = region_r;
        exec_wdata.status = tslot_pkg::STAT_PENDING;
        res_new_id        = id_r;
      end
      tslot_pkg::CMD_POLL: begin
        priority if (id_r == '0) begin
          res_outcome = tslot_pkg::OUTC_INVALID;
        end else if (rdata.owner != id_r) begin
          res_outcome = tslot_pkg::OUTC_GONE;
        end else if (rdata.status != tslot_pkg::STAT_PENDING) begin
          res_outcome = rdata.status;
        end else if (alu_res[0]) begin
          exec_we           = 1'b1;
          exec_wdata.status = tslot_pkg::STAT_COMPLETED;
          res_outcome       = tslot_pkg::OUTC_COMPLETED;
          res_fired         = 1'b1;
        end else begin
          res_outcome = tslot_pkg::OUTC_NOT_DUE;
        end
      end
      tslot_pkg::CMD_CANCEL: begin
        if (id_r != '0 && rdata.owner == id_r && rdata.status == tslot_pkg::STAT_PENDING) begin
          exec_we           = 1'b1;
          exec_wdata.status = tslot_pkg::STAT_CANCELLED;
          res_cancel_ok     = 1'b1;
        end
      end
      tslot_pkg::CMD_CANCEL_REGION: begin
        res_cancel_ok = any_r;
      end
      default: begin
        res_cancel_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    req           = '0;
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    any_nxt       = any_r;
    id_cnt_nxt    = id_cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = idx_r[tslot_pkg::SLOT_W-1:0];
        if (idx_r == LAST_CNT) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + tslot_pkg::CNT_W'(1);
        end
      end
      S_IDLE: begin
        req.re    = in_xfer;
        req.raddr = accept_slot;
        if (in_xfer) begin
          any_nxt = 1'b0;
          if (in_cmd == tslot_pkg::CMD_CREATE) begin
            id_cnt_nxt = next_id;
          end
          if (in_cmd == tslot_pkg::CMD_CANCEL_REGION && in_region_id != '0) begin
            idx_nxt   = tslot_pkg::CNT_W'(1);
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_SWEEP: begin
        req.re    = (idx_r < SLOTS_CNT);
        req.raddr = idx_r[tslot_pkg::SLOT_W-1:0];
        req.we    = hit;
        req.waddr = idx_m1[tslot_pkg::SLOT_W-1:0];
        req.wdata = rdata;
        req.wdata.status = tslot_pkg::STAT_CANCELLED;
        any_nxt   = any_r || hit;
        if (idx_r == SLOTS_CNT) begin
          idx_nxt   = '0;
          state_nxt = S_EXEC;
        end else begin
          idx_nxt = idx_r + tslot_pkg::CNT_W'(1);
        end
      end
      S_EXEC: begin
        req.we    = out_load && exec_we;
        req.waddr = slot_r;
        req.wdata = exec_wdata;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      any_r       <= 1'b0;
      id_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      any_r       <= any_nxt;
      id_cnt_r    <= id_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r    <= in_cmd;
      now_r    <= in_now_ms;
      delay_r  <= in_delay_ms;
      id_r     <= (in_cmd == tslot_pkg::CMD_CREATE) ? next_id : in_timer_id;
      region_r <= in_region_id;
      slot_r   <= accept_slot;
    end
    if (out_load) begin
      new_id_r    <= res_new_id;
      outcome_r   <= res_outcome;
      cancel_ok_r <= res_cancel_ok;
      fired_r     <= res_fired;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_id    = new_id_r;
  assign out_outcome   = outcome_r;
  assign out_cancel_ok = cancel_ok_r;
  assign out_fired     = fired_r;

endmodule

@@ hw/rtl/tslot_checker.sv @@
// Port-level checker for the timer slot table, bound to the top level.
module tslot_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_new_id,
  input logic [1:0]  out_outcome,
  input logic        out_cancel_ok,
  input logic        out_fired
);

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice without a busy cycle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_id) && $stable(out_outcome))
    else $error("stalled result changed");

  a_fired_poll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired |-> out_outcome == tslot_pkg::OUTC_COMPLETED &&
                               out_new_id == '0 && !out_cancel_ok)
    else $error("fired without a completed poll outcome");

  a_create_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_id != '0 |-> out_outcome == tslot_pkg::OUTC_NOT_DUE &&
                                      !out_cancel_ok && !out_fired)
    else $error("create result carries poll or cancel flags");

endmodule

bind timer_slot_table_top tslot_checker u_tslot_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_new_id    (out_new_id),
  .out_outcome   (out_outcome),
  .out_cancel_ok (out_cancel_ok),
  .out_fired     (out_fired)
);

@@ sim/tb_timer_slot_table_top.sv @@
// Self-checking testbench for the timer slot table: directed table, random stream, scoreboard.
module tb_timer_slot_table_top;

  localparam int RAND_ITEMS  = 1525;
  localparam int QUIET_ITEMS = 150;
  localparam int IDLE_LIMIT  = 20000;
  localparam int DIR_ROWS    = 26;

  typedef struct packed {
    logic [tslot_pkg::ID_W-1:0] new_id;
    logic [1:0]                 outcome;
    logic                       cancel_ok;
    logic                       fired;
  } reply_t;

  typedef struct packed {
    logic [1:0]                     cmd;
    logic [tslot_pkg::TIME_W-1:0]   now;
    logic [tslot_pkg::DELAY_W-1:0]  delay;
    logic [tslot_pkg::ID_W-1:0]     tid;
    logic [tslot_pkg::REGION_W-1:0] region;
    logic                           known;
    reply_t                         want;
  } dir_row_t;

  localparam reply_t ZERO_REPLY = '0;

  logic                           clk          = 1'b0;
  logic                           rst_n        = 1'b0;
  logic                           in_valid     = 1'b0;
  logic                           in_stall;
  logic [1:0]                     in_cmd       = tslot_pkg::CMD_POLL;
  logic [tslot_pkg::TIME_W-1:0]   in_now_ms    = '0;
  logic [tslot_pkg::DELAY_W-1:0]  in_delay_ms  = '0;
  logic [tslot_pkg::ID_W-1:0]     in_timer_id  = '0;
  logic [tslot_pkg::REGION_W-1:0] in_region_id = '0;
  logic                           out_valid;
  logic                           out_stall    = 1'b0;
  logic [tslot_pkg::ID_W-1:0]     out_new_id;
  logic [1:0]                     out_outcome;
  logic                           out_cancel_ok;
  logic                           out_fired;

  bit                  quiet = 1'b0;
  int                  mismatches = 0;
  int                  idle_cycles = 0;
  reply_t              timer_replies_q [$];

  // shadow timer table
  bit [tslot_pkg::ID_W-1:0]     tbl_owner  [tslot_pkg::TIMER_SLOTS];
  bit [tslot_pkg::TIME_W-1:0]   tbl_fire   [tslot_pkg::TIMER_SLOTS];
  bit [tslot_pkg::REGION_W-1:0] tbl_region [tslot_pkg::TIMER_SLOTS];
  bit [1:0]                     tbl_status [tslot_pkg::TIMER_SLOTS];
  bit [tslot_pkg::ID_W-1:0]     last_id = '0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{tslot_pkg::CMD_POLL, 48'd0, 32'd0, 32'd0, 32'd0, 1'b1,
      '{32'd0, tslot_pkg::OUTC_INVALID, 1'b0, 1'b0}},
    '{tslot_pkg::CMD_POLL, 48'd0, 32'd0, 32'd1, 32'd0, 1'b1,
      '{32'd0, tslot_pkg::OUTC_GONE, 1'b0, 1'b0}},
    '{tslot_pkg::CMD_CANCEL, 48'd0, 32'd0, 32'd0, 32'd0, 1'b1, ZERO_REPLY},
    '{tslot_pkg::CMD_CANCEL_REGION, 48'd0, 32'd0, 32'd0, 32'd0, 1'b1, ZERO_REPLY},
    '{tslot_pkg::CMD_CANCEL_REGION, 48'd0, 32'd0, 32'd0, 32'd5, 1'b1, ZERO_REPLY},
    '{tslot_pkg::CMD_CREATE, 48'd100, 32'd50, 32'd0, 32'd7, 1'b1,
      '{32'd1, tslot_pkg::OUTC_NOT_DUE, 1'b0, 1'b0}},
    '{tslot_pkg::CMD_POLL, 48'd149, 32'd0, 32'd1, 32'd0, 1'b1,
      '{32'd0, tslot_pkg::OUTC_NOT_DUE, 1'b0, 1'b0}},
    '{tslot_pkg::CMD_POLL, 48'd150, 32'd0, 32'd1, 32'd0, 1'b1,
      '{32'd0, tslot_pkg::OUTC_COMPLETED, 1'b0, 1'b1}},
    '{tslot_pkg::CMD_POLL, 48'd150, 32'd0, 32'd1, 32'd0, 1'b1,
      '{32'd0, tslot_pkg::OUTC_COMPLETED, 1'b0, 1'b0}},
    '{tslot_pkg::CMD_CANCEL, 48'd150, 32'd0, 32'd1, 32'd0, 1'b1, ZERO_REPLY},
    // saturating fire time
    '{tslot_pkg::CMD_CREATE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 1'b1, '{32'd2, tslot_pkg::OUTC_NOT_DUE, 1'b0, 1'b0}},
    '{tslot_pkg::CMD_POLL, 48'hFFFF_FFFF_FFFE, 32'd0, 32'd2, 32'd0, 1'b1,
      '{32'd0, tslot_pkg::OUTC_NOT_DUE, 1'b0, 1'b0}},
    // same slot, other id
    '{tslot_pkg::CMD_POLL, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd4098, 32'd0, 1'b1,
      '{32'd0, tslot_pkg::OUTC_GONE, 1'b0, 1'b0}},
    '{tslot_pkg::CMD_CANCEL, 48'd0, 32'd0, 32'd4098, 32'd0, 1'b1, ZERO_REPLY},
    '{tslot_pkg::CMD_CANCEL, 48'd0, 32'd0, 32'd2, 32'd0, 1'b1,
      '{32'd0, tslot_pkg::OUTC_NOT_DUE, 1'b1, 1'b0}},
    '{tslot_pkg::CMD_POLL, 48'd0, 32'd0, 32'd2, 32'd0, 1'b1,
      '{32'd0, tslot_pkg::OUTC_GONE, 1'b0, 1'b0}},
    '{tslot_pkg::CMD_CANCEL, 48'd0, 32'd0, 32'd2, 32'd0, 1'b0, ZERO_REPLY},
    '{tslot_pkg::CMD_CREATE, 48'd0, 32'd1000, 32'd0, 32'd7, 1'b1,
      '{32'd3, tslot_pkg::OUTC_NOT_DUE, 1'b0, 1'b0}},
    '{tslot_pkg::CMD_CREATE, 48'd0, 32'd1000, 32'd0, 32'd7, 1'b1,
      '{32'd4, tslot_pkg::OUTC_NOT_DUE, 1'b0, 1'b0}},
    '{tslot_pkg::CMD_CREATE, 48'd0, 32'd0, 32'd0, 32'd8, 1'b1,
      '{32'd5, tslot_pkg::OUTC_NOT_DUE, 1'b0, 1'b0}},
    '{tslot_pkg::CMD_CANCEL_REGION, 48'd0, 32'd0, 32'd0, 32'd7, 1'b1,
      '{32'd0, tslot_pkg::OUTC_NOT_DUE, 1'b1, 1'b0}},
    '{tslot_pkg::CMD_POLL, 48'd2000, 32'd0, 32'd3, 32'd0, 1'b0, ZERO_REPLY},
    '{tslot_pkg::CMD_CANCEL_REGION, 48'd0, 32'd0, 32'd0, 32'd7, 1'b0, ZERO_REPLY},
    '{tslot_pkg::CMD_POLL, 48'd0, 32'd0, 32'd5, 32'd0, 1'b0, ZERO_REPLY},
    '{tslot_pkg::CMD_POLL, 48'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1,
      '{32'd0, tslot_pkg::OUTC_GONE, 1'b0, 1'b0}},
    '{tslot_pkg::CMD_CANCEL_REGION, 48'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, ZERO_REPLY}
  };

  timer_slot_table_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_now_ms    (in_now_ms),
    .in_delay_ms  (in_delay_ms),
    .in_timer_id  (in_timer_id),
    .in_region_id (in_region_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_new_id   (out_new_id),
    .out_outcome  (out_outcome),
    .out_cancel_ok(out_cancel_ok),
    .out_fired    (out_fired)
  );

  always #6 clk = ~clk;

  function automatic reply_t timer_table_step(
      input logic [1:0]                     cmd,
      input logic [tslot_pkg::TIME_W-1:0]   now,
      input logic [tslot_pkg::DELAY_W-1:0]  delay,
      input logic [tslot_pkg::ID_W-1:0]     tid,
      input logic [tslot_pkg::REGION_W-1:0] region);
    reply_t                     r;
    logic [tslot_pkg::TIME_W:0] sum;
    int                         s;
    int                         i;
    r = '0;
    case (cmd)
      tslot_pkg::CMD_CREATE: begin
        last_id = (last_id == '1) ? 1 : last_id + 1;
        s = last_id % tslot_pkg::TIMER_SLOTS;
        sum = {1'b0, now} + delay;
        tbl_owner[s]  = last_id;
        tbl_fire[s]   = sum[tslot_pkg::TIME_W] ? '1 : sum[tslot_pkg::TIME_W-1:0];
        tbl_region[s] = region;
        tbl_status[s] = tslot_pkg::STAT_PENDING;
        r.new_id = last_id;
      end
      tslot_pkg::CMD_POLL: begin
        s = tid % tslot_pkg::TIMER_SLOTS;
        if (tid == 0) begin
          r.outcome = tslot_pkg::OUTC_INVALID;
        end else if (tbl_owner[s] != tid) begin
          r.outcome = tslot_pkg::OUTC_GONE;
        end else if (tbl_status[s] != tslot_pkg::STAT_PENDING) begin
          r.outcome = tbl_status[s];
        end else if (now >= tbl_fire[s]) begin
          tbl_status[s] = tslot_pkg::STAT_COMPLETED;
          r.outcome = tslot_pkg::OUTC_COMPLETED;
          r.fired = 1'b1;
        end else begin
          r.outcome = tslot_pkg::OUTC_NOT_DUE;
        end
      end
      tslot_pkg::CMD_CANCEL: begin
        s = tid % tslot_pkg::TIMER_SLOTS;
        if (tid != 0 && tbl_owner[s] == tid &&
            tbl_status[s] == tslot_pkg::STAT_PENDING) begin
          tbl_status[s] = tslot_pkg::STAT_CANCELLED;
          r.cancel_ok = 1'b1;
        end
      end
      default: begin
        if (region != 0) begin
          for (i = 0; i < tslot_pkg::TIMER_SLOTS; i++) begin
            if (tbl_owner[i] != 0 && tbl_region[i] == region &&
                tbl_status[i] == tslot_pkg::STAT_PENDING) begin
              tbl_status[i] = tslot_pkg::STAT_CANCELLED;
              r.cancel_ok = 1'b1;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [tslot_pkg::ID_W-1:0] pick_timer_id();
    logic [tslot_pkg::ID_W-1:0] lo;
    lo = (last_id > 40) ? last_id - 40 : 1;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom;
      2: return $urandom_range(lo, last_id) + tslot_pkg::TIMER_SLOTS;
      default: return (last_id == 0) ? $urandom : $urandom_range(lo, last_id);
    endcase
  endfunction

  function automatic logic [tslot_pkg::REGION_W-1:0] pick_region();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  task automatic send_item(input logic [1:0] cmd,
                           input logic [tslot_pkg::TIME_W-1:0] now,
                           input logic [tslot_pkg::DELAY_W-1:0] delay,
                           input logic [tslot_pkg::ID_W-1:0] tid,
                           input logic [tslot_pkg::REGION_W-1:0] region,
                           input logic known,
                           input reply_t want);
    reply_t pred;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_now_ms    <= now;
    in_delay_ms  <= delay;
    in_timer_id  <= tid;
    in_region_id <= region;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = timer_table_step(cmd, now, delay, tid, region);
    timer_replies_q.push_back(known ? want : pred);
  endtask

  initial begin
    int                             n;
    int                             sel;
    logic [1:0]                     cmd;
    logic [tslot_pkg::TIME_W-1:0]   clock_ms;
    logic [tslot_pkg::TIME_W-1:0]   now;
    logic [tslot_pkg::DELAY_W-1:0]  delay;
    logic [tslot_pkg::ID_W-1:0]     tid;
    logic [tslot_pkg::REGION_W-1:0] region;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[k])
      send_item(dir_rows[k].cmd, dir_rows[k].now, dir_rows[k].delay, dir_rows[k].tid,
                dir_rows[k].region, dir_rows[k].known, dir_rows[k].want);
    clock_ms = 48'd1000;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (n == RAND_ITEMS / 2) begin
        // drain before continuing
        in_valid <= 1'b0;
        do @(posedge clk); while (timer_replies_q.size() != 0);
      end
      clock_ms += tslot_pkg::TIME_W'($urandom_range(0, 40));
      now    = clock_ms;
      delay  = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 300);
      tid    = pick_timer_id();
      region = pick_region();
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        cmd = tslot_pkg::CMD_CREATE;
      end else if (sel < 70) begin
        cmd = tslot_pkg::CMD_POLL;
      end else if (sel < 87) begin
        cmd = tslot_pkg::CMD_CANCEL;
      end else if (sel < 90) begin
        cmd = tslot_pkg::CMD_CANCEL_REGION;
      end else begin
        cmd    = 2'($urandom_range(0, 3));
        now    = tslot_pkg::TIME_W'({$urandom, $urandom});
        delay  = $urandom;
        tid    = $urandom;
        region = $urandom;
      end
      send_item(cmd, now, delay, tid, region, 1'b0, ZERO_REPLY);
    end
    in_valid <= 1'b0;
    while (timer_replies_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && timer_replies_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    @(posedge clk);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    reply_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (timer_replies_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected transfer: id=%0d outcome=%0d cancel=%0b fired=%0b",
                   out_new_id, out_outcome, out_cancel_ok, out_fired);
        mismatches++;
      end else begin
        w = timer_replies_q.pop_front();
        if (out_new_id !== w.new_id || out_outcome !== w.outcome ||
            out_cancel_ok !== w.cancel_ok || out_fired !== w.fired) begin
          if (mismatches < 10)
            $display("mismatch: exp id=%0d outcome=%0d cancel=%0b fired=%0b, %s",
                     w.new_id, w.outcome, w.cancel_ok, w.fired,
                     $sformatf("got id=%0d outcome=%0d cancel=%0b fired=%0b",
                               out_new_id, out_outcome, out_cancel_ok, out_fired));
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
